[rtl/mbr_pkg.sv]
`default_nettype none
package mbr_pkg;

	localparam int BUFFER_BYTES_DEF  = 4096;
	localparam int MAX_READ_BITS_DEF = 64;

	localparam logic [2:0] FN_APPEND = 3'd0;
	localparam logic [2:0] FN_READ   = 3'd1;
	localparam logic [2:0] FN_PEEK   = 3'd2;
	localparam logic [2:0] FN_SKIP   = 3'd3;
	localparam logic [2:0] FN_REWIND = 3'd4;
	localparam logic [2:0] FN_CLEAR  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  data_byte;
		logic [6:0]  bit_count;
		logic [12:0] byte_count;
	} cmd_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic [15:0] bits_left;
		logic [12:0] bytes_held;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_READ,
		OP_PEEK,
		OP_SKIP,
		OP_REWIND,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        too_many;
		logic [7:0]  data_byte;
		logic [6:0]  bit_count;
		logic [12:0] byte_count;
	} task_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_GATHER,
		S_EMIT
	} back_state_t;

endpackage
`default_nettype wire

[rtl/msb_first_bit_reader.sv]
`default_nettype none
// MSB-first bit reader over an appendable byte buffer. Commands enter through a
// decoder and a two-beat queue, so up to two commands are taken while the
// executor works or a result beat waits on rsp_stall. Append, skip, rewind, clear,
// any failed read and a zero-length read at a byte boundary read no stored
// byte; a read or peek that touches N stored bytes (N up to 9, and 1 for a
// zero-length read inside a byte) fetches them one at a time, as the byte memory
// delivers one byte per cycle on its single read port.
// The memory is never cleared; only bytes below the fill length are read.
module msb_first_bit_reader #(
	parameter int BUFFER_BYTES  = mbr_pkg::BUFFER_BYTES_DEF,
	parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire mbr_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output mbr_pkg::rsp_t      rsp
);
	import mbr_pkg::*;

	task_t dec_task, head;
	logic  full, not_empty, pop;

	assign cmd_stall = full;

	mbr_front #(
		.MAX_READ_BITS(MAX_READ_BITS)
	) u_front (
		.cmd (cmd),
		.tsk (dec_task)
	);

	mbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid && !full),
		.push_data (dec_task),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	mbr_back #(
		.BUFFER_BYTES  (BUFFER_BYTES),
		.MAX_READ_BITS (MAX_READ_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

[rtl/mbr_ram.sv]
`default_nettype none
module mbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/mbr_front.sv]
`default_nettype none
module mbr_front #(
	parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEF
) (
	input  wire mbr_pkg::cmd_t  cmd,
	output mbr_pkg::task_t      tsk
);
	import mbr_pkg::*;

	always_comb begin
		tsk.data_byte  = cmd.data_byte;
		tsk.bit_count  = cmd.bit_count;
		tsk.byte_count = cmd.byte_count;
		tsk.too_many   = cmd.bit_count > 7'(MAX_READ_BITS);
		unique case (cmd.func)
			FN_APPEND: tsk.op = OP_APPEND;
			FN_READ:   tsk.op = OP_READ;
			FN_PEEK:   tsk.op = OP_PEEK;
			FN_SKIP:   tsk.op = OP_SKIP;
			FN_REWIND: tsk.op = OP_REWIND;
			FN_CLEAR:  tsk.op = OP_CLEAR;
			default:   tsk.op = OP_NOP;
		endcase
	end
endmodule
`default_nettype wire

[rtl/mbr_queue.sv]
`default_nettype none
module mbr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mbr_pkg::task_t push_data,
	output logic                full,
	input  wire logic           pop,
	output mbr_pkg::task_t      head,
	output logic                not_empty
);
	import mbr_pkg::*;

	task_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/mbr_back.sv]
`default_nettype none
module mbr_back #(
	parameter int BUFFER_BYTES  = mbr_pkg::BUFFER_BYTES_DEF,
	parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mbr_pkg::task_t head,
	input  wire logic           not_empty,
	output logic                pop,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output mbr_pkg::rsp_t       rsp
);
	import mbr_pkg::*;

	localparam int AW   = $clog2(BUFFER_BYTES);
	localparam int FW   = $clog2(BUFFER_BYTES + 1);
	localparam int UW   = FW + 3;
	localparam int SW   = ((FW > 13) ? FW : 13) + 1;
	localparam int KMAX = (MAX_READ_BITS + 14) / 8;
	localparam int KW   = $clog2(KMAX + 1);
	localparam int VW   = (8 * KMAX > 64) ? 8 * KMAX : 64;

	back_state_t state_q, state_d;
	task_t       cur_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] pos_q;
	logic [2:0]    bit_q;
	logic [63:0]   res_value_q;
	logic [1:0]    res_status_q;
	logic [KW-1:0] k_q, iss_q, rcv_q;
	logic [2:0]    tail_q;
	logic          pend_q;
	logic [VW-1:0] acc_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic [UW-1:0] unread, unread_after, new_total;
	logic [7:0]    span;
	logic [KW-1:0] k_need;
	logic [SW-1:0] skip_end;
	logic          room, count_ok, go_gather, gather_done;
	logic          ram_we, ram_re, out_load;
	logic [7:0]    rdata;
	logic [VW-1:0] shifted;
	logic [63:0]   mask, gathered;

	assign unread       = {fill_q, 3'b000} - {pos_q, bit_q};
	assign span         = 8'(bit_q) + 8'(cur_q.bit_count) + 8'd7;
	assign k_need       = KW'(span[7:3]);
	assign skip_end     = SW'(pos_q) + SW'(cur_q.byte_count);
	assign room         = fill_q < FW'(BUFFER_BYTES);
	assign count_ok     = !cur_q.too_many && UW'(cur_q.bit_count) <= unread;
	assign go_gather    = (cur_q.op == OP_READ || cur_q.op == OP_PEEK) && count_ok
	                      && k_need != '0;
	assign gather_done  = rcv_q == k_q;
	assign new_total    = {pos_q, bit_q} + UW'(cur_q.bit_count);
	assign shifted      = acc_q >> tail_q;
	assign mask         = (cur_q.bit_count >= 7'd64) ? '1 : ((64'd1 << cur_q.bit_count) - 64'd1);
	assign gathered     = shifted[63:0] & mask;
	assign unread_after = unread;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (not_empty) state_d = S_EXEC;
			S_EXEC:   state_d = go_gather ? S_GATHER : S_EMIT;
			S_GATHER: if (gather_done) state_d = S_EMIT;
			S_EMIT:   if (!out_valid_q || !rsp_stall) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE:   pop      = not_empty;
			S_EXEC:   ram_we   = cur_q.op == OP_APPEND && room;
			S_GATHER: ram_re   = iss_q < k_q;
			S_EMIT:   out_load = !out_valid_q || !rsp_stall;
			default:  pop      = 1'b0;
		endcase
	end

	mbr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (cur_q.data_byte),
		.re    (ram_re),
		.raddr (pos_q[AW-1:0] + AW'(iss_q)),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (state_q == S_EXEC) begin
			k_q    <= k_need;
			tail_q <= 3'(3'd0 - span[2:0] + 3'd7);
			acc_q  <= '0;
		end else if (pend_q) begin
			acc_q <= {acc_q[VW-9:0], rdata};
		end
		if (out_load) begin
			out_q.value      <= res_value_q;
			out_q.status     <= res_status_q;
			out_q.bits_left  <= 16'(unread_after);
			out_q.bytes_held <= 13'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			pos_q        <= '0;
			bit_q        <= '0;
			iss_q        <= '0;
			rcv_q        <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			pend_q  <= ram_re;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_EXEC) begin
				res_value_q  <= '0;
				res_status_q <= ST_OK;
				iss_q        <= '0;
				rcv_q        <= '0;
				unique case (cur_q.op)
					OP_APPEND: begin
						if (room) fill_q <= fill_q + FW'(1);
						else      res_status_q <= ST_RANGE;
					end
					OP_READ, OP_PEEK: begin
						if (cur_q.too_many) begin
							res_status_q <= ST_COUNT;
						end else if (!count_ok) begin
							res_status_q <= ST_RANGE;
							if (cur_q.op == OP_READ) begin
								pos_q <= fill_q;
								bit_q <= 3'd0;
							end
						end
					end
					OP_SKIP: begin
						if (skip_end >= SW'(fill_q)) res_status_q <= ST_RANGE;
						else                         pos_q <= FW'(skip_end);
					end
					OP_REWIND: begin
						pos_q <= '0;
						bit_q <= 3'd0;
					end
					OP_CLEAR: begin
						fill_q <= '0;
						pos_q  <= '0;
						bit_q  <= 3'd0;
					end
					default: res_status_q <= ST_OK;
				endcase
			end else if (state_q == S_GATHER) begin
				if (ram_re) iss_q <= iss_q + KW'(1);
				if (pend_q) rcv_q <= rcv_q + KW'(1);
				if (gather_done) begin
					res_value_q <= gathered;
					// advance only for read; peek keeps the position
					if (cur_q.op == OP_READ) begin
						pos_q <= new_total[UW-1:3];
						bit_q <= new_total[2:0];
					end
				end
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= fill_q) else $error("position beyond fill");
	a_bit_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q != 3'd0 |-> pos_q < fill_q) else $error("bit offset at end of buffer");
	a_pend_gather: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == S_GATHER) else $error("read data outside gather");
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GATHER |-> iss_q <= k_q && rcv_q <= iss_q)
		else $error("gather counters out of order");
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
	import mbr_pkg::*;

	localparam int DEPTH = 4096;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	msb_first_bit_reader u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// reader mirror
	logic [7:0]  mirror_bytes [DEPTH];
	int          mirror_fill;
	int          mirror_byte_pos;
	int          mirror_bit_pos;
	rsp_t        pending_rsp [$];

	int mismatches;
	int rsp_seen;
	int cmd_sent;
	int idle_cycles;
	bit hold_rsp;
	bit rsp_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unread_count();
		int total;
		int used;
		total = mirror_fill * 8;
		used = mirror_byte_pos * 8 + mirror_bit_pos;
		return (used >= total) ? 0 : total - used;
	endfunction

	function automatic rsp_t predict_reader(cmd_t c);
		rsp_t r;
		int p;
		int i;
		r = '0;
		case (c.func)
			FN_APPEND: begin
				if (mirror_fill >= DEPTH) begin
					r.status = ST_RANGE;
				end else begin
					mirror_bytes[mirror_fill] = c.data_byte;
					mirror_fill++;
				end
			end
			FN_READ, FN_PEEK: begin
				if (c.bit_count > 64) begin
					r.status = ST_COUNT;
				end else if (c.bit_count > unread_count()) begin
					r.status = ST_RANGE;
					if (c.func == FN_READ) begin
						mirror_byte_pos = mirror_fill;
						mirror_bit_pos = 0;
					end
				end else begin
					p = mirror_byte_pos * 8 + mirror_bit_pos;
					for (i = 0; i < c.bit_count; i++) begin
						r.value = {r.value[62:0], mirror_bytes[p >> 3][7 - (p & 7)]};
						p++;
					end
					if (c.func == FN_READ) begin
						mirror_byte_pos = p >> 3;
						mirror_bit_pos = p & 7;
					end
				end
			end
			FN_SKIP: begin
				if (mirror_byte_pos + c.byte_count >= mirror_fill)
					r.status = ST_RANGE;
				else
					mirror_byte_pos += c.byte_count;
			end
			FN_REWIND: begin
				mirror_byte_pos = 0;
				mirror_bit_pos = 0;
			end
			FN_CLEAR: begin
				mirror_fill = 0;
				mirror_byte_pos = 0;
				mirror_bit_pos = 0;
			end
			default: ;
		endcase
		r.bits_left = 16'(unread_count());
		r.bytes_held = 13'(mirror_fill);
		return r;
	endfunction

	function automatic int random_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// send one beat; prediction happens at acceptance
	task automatic send_cmd(cmd_t c, bit gaps = 1'b1);
		int g;
		g = gaps ? random_gap() : 0;
		if (g != 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		pending_rsp.push_back(predict_reader(c));
		cmd_sent++;
	endtask

	function automatic cmd_t make_cmd(logic [2:0] f, int d, int bits, int bytes);
		cmd_t c;
		c.func = f;
		c.data_byte = 8'(d);
		c.bit_count = 7'(bits);
		c.byte_count = 13'(bytes);
		return c;
	endfunction

	function automatic cmd_t noisy_cmd(logic [2:0] f);
		cmd_t c;
		c.func = f;
		c.data_byte = 8'($urandom);
		c.bit_count = 7'($urandom);
		c.byte_count = 13'($urandom);
		return c;
	endfunction

	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %h", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: value %h/%h status %0d/%0d bits_left %0d/%0d held %0d/%0d",
							want.value, rsp.value, want.status, rsp.status,
							want.bits_left, rsp.bits_left, want.bytes_held, rsp.bytes_held);
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int g;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				@(posedge clk);
			end else if (rsp_quiet) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				g = random_gap();
				if (g != 0) begin
					rsp_stall <= 1'b1;
					repeat (g) @(posedge clk);
				end
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", pending_rsp.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic test_directed();
		send_cmd(make_cmd(FN_READ, 0, 0, 0));
		send_cmd(make_cmd(FN_READ, 0, 1, 0));
		send_cmd(make_cmd(FN_SKIP, 0, 0, 0));
		for (int i = 0; i < 10; i++)
			send_cmd(make_cmd(FN_APPEND, (i == 0) ? 8'hff : (i == 1) ? 8'h00 : $urandom, 0, 0));
		send_cmd(make_cmd(FN_PEEK, 0, 64, 0));
		send_cmd(make_cmd(FN_READ, 0, 3, 0));
		send_cmd(make_cmd(FN_READ, 0, 64, 0));
		send_cmd(make_cmd(FN_PEEK, 0, 127, 0));
		send_cmd(make_cmd(FN_READ, 0, 65, 0));
		send_cmd(make_cmd(FN_PEEK, 0, 64, 0));
		send_cmd(make_cmd(FN_SKIP, 0, 0, 8191));
		send_cmd(make_cmd(FN_SKIP, 0, 0, 1));
		send_cmd(make_cmd(FN_READ, 0, 64, 0));
		send_cmd(make_cmd(FN_REWIND, 0, 0, 0));
		send_cmd(make_cmd(3'd6, 8'hff, 127, 8191));
		send_cmd(make_cmd(3'd7, 0, 0, 0));
		send_cmd(make_cmd(FN_CLEAR, 0, 0, 0));
	endtask

	task automatic test_backpressure();
		hold_rsp = 1'b1;
		fork
			begin
				for (int i = 0; i < 12; i++)
					send_cmd(make_cmd(FN_APPEND, $urandom, 0, 0), 1'b0);
				cmd_valid <= 1'b0;
			end
			begin
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end
		join
		drain();
		// results only, no input gaps
		rsp_quiet = 1'b1;
		for (int i = 0; i < 12; i++)
			send_cmd(make_cmd(FN_READ, 0, $urandom_range(0, 12), 0), 1'b0);
		drain();
		rsp_quiet = 1'b0;
		send_cmd(make_cmd(FN_CLEAR, 0, 0, 0));
	endtask

	// parser-like traffic: random appends, reads and peeks, with skips, rewinds, clears and unused codes mixed in
	task automatic test_random(int n);
		int sent;
		int roll;
		cmd_t c;
		sent = 0;
		while (sent < n) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				c = make_cmd(FN_CLEAR, 0, 0, 0);
			end else if (roll < 35 || mirror_fill < 2) begin
				c = noisy_cmd(FN_APPEND);
			end else if (roll < 65) begin
				c = noisy_cmd(FN_READ);
				c.bit_count = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64));
			end else if (roll < 82) begin
				c = noisy_cmd(FN_PEEK);
				c.bit_count = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64));
			end else if (roll < 90) begin
				c = noisy_cmd(FN_SKIP);
				if ($urandom_range(0, 3) != 0) c.byte_count = 13'($urandom_range(0, 12));
			end else if (roll < 96) begin
				c = noisy_cmd(FN_REWIND);
			end else begin
				c = noisy_cmd(3'($urandom_range(6, 7)));
			end
			send_cmd(c);
			sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		mismatches = 0;
		rsp_seen = 0;
		cmd_sent = 0;
		idle_cycles = 0;
		hold_rsp = 1'b0;
		rsp_quiet = 1'b0;
		mirror_fill = 0;
		mirror_byte_pos = 0;
		mirror_bit_pos = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1700);
		drain();
		$display("sent %0d commands (append, read, peek, skip, rewind, clear, unused)", cmd_sent);
		$display("checked %0d result beats, including a long output stall that fills the queue",
			rsp_seen);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_rsp.size());
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/mbr_pkg.sv
rtl/mbr_ram.sv
rtl/mbr_front.sv
rtl/mbr_queue.sv
rtl/mbr_back.sv
rtl/msb_first_bit_reader.sv
dv/tb.sv
